// ===== sv/ssrp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssrp_pkg
// Shared constants and codes for the shortest seek request picker.
// ----------------------------------------------------------------------------
package ssrp_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int SECTOR_BITS_DEF = 48;
    localparam int TAG_BITS_DEF    = 8;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 2'd0,
        MODE_DISPATCH = 2'd1,
        MODE_REMOVE   = 2'd2,
        MODE_NOP      = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_FULL       = 3'd3,
        ST_NOTFOUND   = 3'd4
    } status_t;

endpackage

// ===== sv/ssrp_req_if.sv =====
// ----------------------------------------------------------------------------
// ssrp_req_if
// Request channel: operation, sector and tag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssrp_req_if #(
    parameter int SECTOR_BITS = ssrp_pkg::SECTOR_BITS_DEF,
    parameter int TAG_BITS    = ssrp_pkg::TAG_BITS_DEF
);
    import ssrp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [SECTOR_BITS-1:0] request_sector;
    logic [TAG_BITS-1:0]    request_tag;

    modport source (output valid, output mode, output request_sector, output request_tag,
                    input ready);
    modport sink   (input valid, input mode, input request_sector, input request_tag,
                    output ready);
endinterface

// ===== sv/ssrp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ssrp_rsp_if
// Result channel: status, dispatched request and occupancy with valid/ready.
// ----------------------------------------------------------------------------
interface ssrp_rsp_if #(
    parameter int DEPTH       = ssrp_pkg::DEPTH_DEF,
    parameter int SECTOR_BITS = ssrp_pkg::SECTOR_BITS_DEF,
    parameter int TAG_BITS    = ssrp_pkg::TAG_BITS_DEF
);
    import ssrp_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [TAG_BITS-1:0]    out_tag;
    logic [SECTOR_BITS-1:0] out_sector;
    logic [CNT_W-1:0]       occupancy;

    modport source (output valid, output status, output out_tag, output out_sector,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_tag, input out_sector,
                    input occupancy, output ready);
endinterface

// ===== sv/ssrp_ram.sv =====
// ----------------------------------------------------------------------------
// ssrp_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ssrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ssrp_seq.sv =====
// ----------------------------------------------------------------------------
// ssrp_seq
// Sequencer: sorted insert, nearest-sector scan, tag scan and compaction
// over the entry RAM, plus the result register.
// ----------------------------------------------------------------------------
module ssrp_seq #(
    parameter int DEPTH       = ssrp_pkg::DEPTH_DEF,
    parameter int SECTOR_BITS = ssrp_pkg::SECTOR_BITS_DEF,
    parameter int TAG_BITS    = ssrp_pkg::TAG_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ssrp_req_if.sink                           in_chan,
    ssrp_rsp_if.source                         out_chan,
    output logic                               ram_we,
    output logic [$clog2(DEPTH)-1:0]           ram_waddr,
    output logic [SECTOR_BITS+TAG_BITS-1:0]    ram_wdata,
    output logic [$clog2(DEPTH)-1:0]           ram_raddr,
    input  logic [SECTOR_BITS+TAG_BITS-1:0]    ram_rdata
);
    import ssrp_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = SECTOR_BITS + TAG_BITS;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_ADD_SH   = 7'b0000010,
        S_ADD_LAST = 7'b0000100,
        S_DSP_SCAN = 7'b0001000,
        S_REM_SCAN = 7'b0010000,
        S_DROP     = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SECTOR_BITS-1:0] last_pos_reg, last_pos_next;
    logic [SECTOR_BITS-1:0] req_sec_reg, req_sec_next;
    logic [TAG_BITS-1:0]    req_tag_reg, req_tag_next;
    logic [CNT_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]       s1_idx_reg, s1_idx_next;
    logic                   d_valid_reg, d_valid_next;
    logic [SECTOR_BITS-1:0] dist_reg, dist_next;
    logic [SECTOR_BITS-1:0] d_sec_reg, d_sec_next;
    logic [TAG_BITS-1:0]    d_tag_reg, d_tag_next;
    logic [IDX_W-1:0]       d_idx_reg, d_idx_next;
    logic                   have_best_reg, have_best_next;
    logic [SECTOR_BITS-1:0] least_reg, least_next;
    logic [SECTOR_BITS-1:0] best_sec_reg, best_sec_next;
    logic [TAG_BITS-1:0]    best_tag_reg, best_tag_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]       wr_idx_reg, wr_idx_next;
    status_t                res_status_reg, res_status_next;
    logic [TAG_BITS-1:0]    res_tag_reg, res_tag_next;
    logic [SECTOR_BITS-1:0] res_sec_reg, res_sec_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [TAG_BITS-1:0]    out_tag_reg, out_tag_next;
    logic [SECTOR_BITS-1:0] out_sec_reg, out_sec_next;
    logic [CNT_W-1:0]       out_occ_reg, out_occ_next;

    logic [SECTOR_BITS-1:0] rd_sec;
    logic [TAG_BITS-1:0]    rd_tag;
    logic [SECTOR_BITS-1:0] rd_dist;
    logic [CNT_W-1:0]       cnt_m1;
    logic [CNT_W-1:0]       wr_idx_ext;
    logic [ENT_W-1:0]       new_entry;
    logic                   accept;
    logic                   out_load;
    logic                   drop_start;
    logic [IDX_W-1:0]       drop_k;

    assign rd_sec     = ram_rdata[ENT_W-1:TAG_BITS];
    assign rd_tag     = ram_rdata[TAG_BITS-1:0];
    assign rd_dist    = (rd_sec < last_pos_reg) ? (last_pos_reg - rd_sec)
                                                : (rd_sec - last_pos_reg);
    assign cnt_m1     = count_reg - CNT_W'(1);
    assign wr_idx_ext = CNT_W'(wr_idx_reg);
    assign new_entry  = {req_sec_reg, req_tag_reg};

    assign in_chan.ready = (state_reg == S_IDLE);
    assign accept        = in_chan.valid && in_chan.ready;
    assign out_load      = (state_reg == S_RESP) && (!out_valid_reg || out_chan.ready);

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.status     = out_status_reg;
    assign out_chan.out_tag    = out_tag_reg;
    assign out_chan.out_sector = out_sec_reg;
    assign out_chan.occupancy  = out_occ_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_pos_next   = last_pos_reg;
        req_sec_next    = req_sec_reg;
        req_tag_next    = req_tag_reg;
        rd_ptr_next     = rd_ptr_reg;
        s1_valid_next   = 1'b0;
        s1_idx_next     = s1_idx_reg;
        d_valid_next    = 1'b0;
        dist_next       = dist_reg;
        d_sec_next      = d_sec_reg;
        d_tag_next      = d_tag_reg;
        d_idx_next      = d_idx_reg;
        have_best_next  = have_best_reg;
        least_next      = least_reg;
        best_sec_next   = best_sec_reg;
        best_tag_next   = best_tag_reg;
        best_idx_next   = best_idx_reg;
        wr_idx_next     = wr_idx_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_sec_next    = res_sec_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_sec_next    = out_sec_reg;
        out_occ_next    = out_occ_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        drop_start      = 1'b0;
        drop_k          = '0;

        if (out_valid_reg && out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_sec_next    = in_chan.request_sector;
                    req_tag_next    = in_chan.request_tag;
                    res_status_next = ST_DONE;
                    res_tag_next    = '0;
                    res_sec_next    = '0;
                    unique case (mode_t'(in_chan.mode))
                        MODE_ADD:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_RESP;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = {in_chan.request_sector, in_chan.request_tag};
                                count_next = CNT_W'(1);
                                state_next = S_RESP;
                            end
                            else
                            begin
                                // walk down from the top, moving larger sectors up one slot
                                ram_raddr   = cnt_m1[IDX_W-1:0];
                                wr_idx_next = count_reg[IDX_W-1:0];
                                count_next  = count_reg + CNT_W'(1);
                                state_next  = S_ADD_SH;
                            end
                        end
                        MODE_DISPATCH:
                        begin
                            if (count_reg == '0)
                            begin
                                last_pos_next   = '0;
                                res_status_next = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                ram_raddr      = '0;
                                s1_valid_next  = 1'b1;
                                s1_idx_next    = '0;
                                rd_ptr_next    = CNT_W'(1);
                                have_best_next = 1'b0;
                                state_next     = S_DSP_SCAN;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NOTFOUND;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                ram_raddr     = '0;
                                s1_valid_next = 1'b1;
                                s1_idx_next   = '0;
                                rd_ptr_next   = CNT_W'(1);
                                state_next    = S_REM_SCAN;
                            end
                        end
                        MODE_NOP:
                        begin
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_ADD_SH:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_idx_reg;
                if (rd_sec > req_sec_reg)
                begin
                    ram_wdata = ram_rdata;
                    if (wr_idx_reg == IDX_W'(1))
                    begin
                        state_next = S_ADD_LAST;
                    end
                    else
                    begin
                        ram_raddr   = wr_idx_reg - IDX_W'(2);
                        wr_idx_next = wr_idx_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    ram_wdata  = new_entry;
                    state_next = S_RESP;
                end
            end
            S_ADD_LAST:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = new_entry;
                state_next = S_RESP;
            end
            S_DSP_SCAN:
            begin
                if (rd_ptr_reg < count_reg)
                begin
                    ram_raddr     = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next   = rd_ptr_reg + CNT_W'(1);
                    s1_valid_next = 1'b1;
                    s1_idx_next   = rd_ptr_reg[IDX_W-1:0];
                end
                // stage one: distance
                if (s1_valid_reg)
                begin
                    d_valid_next = 1'b1;
                    dist_next    = rd_dist;
                    d_sec_next   = rd_sec;
                    d_tag_next   = rd_tag;
                    d_idx_next   = s1_idx_reg;
                end
                // stage two: strict compare keeps the earliest entry on ties
                if (d_valid_reg && (!have_best_reg || (dist_reg < least_reg)))
                begin
                    have_best_next = 1'b1;
                    least_next     = dist_reg;
                    best_sec_next  = d_sec_reg;
                    best_tag_next  = d_tag_reg;
                    best_idx_next  = d_idx_reg;
                end
                if (!s1_valid_reg && !d_valid_reg)
                begin
                    last_pos_next   = best_sec_reg;
                    res_status_next = ST_DISPATCHED;
                    res_tag_next    = best_tag_reg;
                    res_sec_next    = best_sec_reg;
                    drop_start      = 1'b1;
                    drop_k          = best_idx_reg;
                end
            end
            S_REM_SCAN:
            begin
                if (s1_valid_reg)
                begin
                    if (rd_tag == req_tag_reg)
                    begin
                        res_status_next = ST_DONE;
                        drop_start      = 1'b1;
                        drop_k          = s1_idx_reg;
                    end
                    else if (rd_ptr_reg < count_reg)
                    begin
                        ram_raddr     = rd_ptr_reg[IDX_W-1:0];
                        rd_ptr_next   = rd_ptr_reg + CNT_W'(1);
                        s1_valid_next = 1'b1;
                        s1_idx_next   = rd_ptr_reg[IDX_W-1:0];
                    end
                end
                else
                begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_RESP;
                end
            end
            S_DROP:
            begin
                // close the gap: entry above moves down one slot
                ram_we    = 1'b1;
                ram_waddr = wr_idx_reg;
                ram_wdata = ram_rdata;
                if (wr_idx_ext + CNT_W'(2) == count_reg)
                begin
                    count_next = cnt_m1;
                    state_next = S_RESP;
                end
                else
                begin
                    ram_raddr   = wr_idx_reg + IDX_W'(2);
                    wr_idx_next = wr_idx_reg + IDX_W'(1);
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_tag_next    = res_tag_reg;
                    out_sec_next    = res_sec_reg;
                    out_occ_next    = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (drop_start)
        begin
            if (CNT_W'(drop_k) + CNT_W'(1) == count_reg)
            begin
                count_next = cnt_m1;
                state_next = S_RESP;
            end
            else
            begin
                ram_raddr   = drop_k + IDX_W'(1);
                wr_idx_next = drop_k;
                state_next  = S_DROP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_pos_reg  <= '0;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            d_valid_reg   <= 1'b0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_pos_reg  <= last_pos_next;
            rd_ptr_reg    <= rd_ptr_next;
            s1_valid_reg  <= s1_valid_next;
            d_valid_reg   <= d_valid_next;
            have_best_reg <= have_best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_sec_reg    <= req_sec_next;
        req_tag_reg    <= req_tag_next;
        s1_idx_reg     <= s1_idx_next;
        dist_reg       <= dist_next;
        d_sec_reg      <= d_sec_next;
        d_tag_reg      <= d_tag_next;
        d_idx_reg      <= d_idx_next;
        least_reg      <= least_next;
        best_sec_reg   <= best_sec_next;
        best_tag_reg   <= best_tag_next;
        best_idx_reg   <= best_idx_next;
        wr_idx_reg     <= wr_idx_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_sec_reg    <= res_sec_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_sec_reg    <= out_sec_next;
        out_occ_reg    <= out_occ_next;
    end

    a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_chan.mode == MODE_ADD) && (count_reg == CNT_W'(DEPTH)))
        |=> $stable(count_reg))
        else $error("add to a full store changed the count");

    a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("result not registered on leaving the response state");

    a_drop_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DROP) |-> (ram_we && (wr_idx_ext + CNT_W'(2) <= count_reg)))
        else $error("compaction write outside the live entries");

    a_dispatch_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (res_status_reg == ST_DISPATCHED)) |-> (res_sec_reg == last_pos_reg))
        else $error("dispatched sector differs from the last position");

endmodule

// ===== sv/shortest_seek_request_picker.sv =====
// ----------------------------------------------------------------------------
// shortest_seek_request_picker
// Add moves each entry above the insert point up one slot; an empty or full store responds directly.
// Dispatch scans every entry, then closes the gap above the winner; an empty store responds directly.
// Remove scans up to the match, then closes the gap; a miss scans every entry; empty responds directly.
// One request at a time; the entry RAM (one read, one write a cycle) sets the pace.
// Reset clears the count and the last position; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
module shortest_seek_request_picker #(
    parameter int DEPTH       = ssrp_pkg::DEPTH_DEF,
    parameter int SECTOR_BITS = ssrp_pkg::SECTOR_BITS_DEF,
    parameter int TAG_BITS    = ssrp_pkg::TAG_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ssrp_req_if.sink   in_chan,
    ssrp_rsp_if.source out_chan
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int ENT_W = SECTOR_BITS + TAG_BITS;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    // entries kept in ascending sector order, equal sectors in arrival order
    ssrp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ssrp_seq #(
        .DEPTH       (DEPTH),
        .SECTOR_BITS (SECTOR_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_chan   (in_chan),
        .out_chan  (out_chan),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule
